// ===== design/sl1p_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sl1p_pkg
// Shared widths, sign codes and controller/datapath interface structs for the
// sorted-L1 proximal operator.
// ----------------------------------------------------------------------------
package sl1p_pkg;

	localparam int MAX_LENGTH_DEF = 64;
	localparam int MAG_W          = 32;
	localparam int WGT_W          = 31;
	localparam int SUM_W          = 40;

	// sign codes kept per coefficient
	localparam logic [1:0] SIGN_ZERO = 2'd0;
	localparam logic [1:0] SIGN_POS  = 2'd1;
	localparam logic [1:0] SIGN_NEG  = 2'd3;

	// commands from the controller
	typedef struct packed {
		logic load;
		logic sort_latch;
		logic sort_scan;
		logic sort_wr;
		logic mag_sel;
		logic pool_wlatch;
		logic pool_push;
		logic pool_merge;
		logic pool_div;
		logic pool_next;
		logic fill_wr;
		logic fill_pop;
		logic emit_cap;
		logic emit_fire;
	} cmd_t;

	// status back to the controller
	typedef struct packed {
		logic last_in;
		logic j_done;
		logic sort_last;
		logic depth_zero;
		logic merge_ok;
		logic div_done;
		logic fill_done;
		logic fill_pop;
		logic emit_last;
	} status_t;

endpackage
`default_nettype wire

// ===== design/sl1p_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sl1p_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sl1p_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== design/sl1p_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sl1p_div
// Iterative restoring divider, one quotient bit per cycle, signed dividend
// by unsigned divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module sl1p_div import sl1p_pkg::*; #(
	parameter int N_W = SUM_W,
	parameter int D_W = 7
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic signed [N_W-1:0] dividend,
	input  wire logic [D_W-1:0]        divisor,
	output logic                       done,
	output logic signed [N_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [N_W-1:0]   q_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   d_q;
	logic [D_W:0]     trial;
	logic             fits;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, q_q[N_W-1]};
	assign fits  = trial >= {1'b0, d_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(N_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[N_W-1];
			q_q   <= dividend[N_W-1] ? (N_W'(0) - N_W'(dividend)) : N_W'(dividend);
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			q_q   <= {q_q[N_W-2:0], fits};
			rem_q <= fits ? D_W'(trial - {1'b0, d_q}) : D_W'(trial);
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(q_q) : $signed(q_q);

endmodule
`default_nettype wire

// ===== design/sl1p_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sl1p_datapath
// Coefficient stores, rank counting sort, pooling stack with divider,
// per-rank result fill and output register.
// ----------------------------------------------------------------------------
module sl1p_datapath import sl1p_pkg::*; #(
	parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic signed [MAG_W-1:0] beta_value,
	input  wire logic [WGT_W-1:0]        lambda_value,
	input  wire logic                    last_element,
	input  wire cmd_t                    cmd,
	output status_t                      sts,
	output logic signed [MAG_W-1:0]      result_value,
	output logic                         last_result
);

	localparam int IW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int CW    = $clog2(MAX_LENGTH + 1);
	localparam int STK_W = 2 * SUM_W + IW;

	// counters and working registers
	logic [CW-1:0]           cnt_q, n_q, i_q, j_q, jd_q, acc_q, depth_q;
	logic                    vld_q;
	logic [MAG_W-1:0]        cur_q;
	logic [WGT_W-1:0]        w_q;
	logic signed [SUM_W-1:0] top_sum_q, top_mean_q;
	logic [IW-1:0]           top_start_q;
	logic signed [MAG_W-1:0] result_q;
	logic                    last_q;

	// RAM ports
	logic [MAG_W-1:0] mag_a_rd, mag_b_rd, byrank_rd;
	logic [1:0]       sign_rd, sign_in;
	logic [WGT_W-1:0] wgt_rd;
	logic [IW-1:0]    order_rd, rank_rd, mag_a_ra;
	logic [STK_W-1:0] stk_rd;
	logic [MAG_W-1:0] mag_in;
	logic             gt;
	logic signed [SUM_W-1:0] s_new, below_sum, below_mean, merged_sum, quot;
	logic [IW-1:0]    below_start;
	logic [CW-1:0]    blk_len;
	logic             div_start;
	logic             div_done;
	logic [MAG_W-1:0] clamp_d;
	logic             stk_we;

	// magnitude and sign of the incoming coefficient
	assign mag_in  = beta_value[MAG_W-1] ? (MAG_W'(0) - MAG_W'(beta_value))
	                                     : MAG_W'(beta_value);
	assign sign_in = (beta_value == '0) ? SIGN_ZERO
	               : (beta_value[MAG_W-1] ? SIGN_NEG : SIGN_POS);

	assign mag_a_ra = cmd.mag_sel ? order_rd : i_q[IW-1:0];

	sl1p_ram #(.WIDTH(MAG_W), .DEPTH(MAX_LENGTH)) u_mag_a (
		.clk(clk), .we(cmd.load), .waddr(cnt_q[IW-1:0]), .wdata(mag_in),
		.raddr(mag_a_ra), .rdata(mag_a_rd)
	);
	sl1p_ram #(.WIDTH(MAG_W), .DEPTH(MAX_LENGTH)) u_mag_b (
		.clk(clk), .we(cmd.load), .waddr(cnt_q[IW-1:0]), .wdata(mag_in),
		.raddr(j_q[IW-1:0]), .rdata(mag_b_rd)
	);
	sl1p_ram #(.WIDTH(2), .DEPTH(MAX_LENGTH)) u_sign (
		.clk(clk), .we(cmd.load), .waddr(cnt_q[IW-1:0]), .wdata(sign_in),
		.raddr(j_q[IW-1:0]), .rdata(sign_rd)
	);
	sl1p_ram #(.WIDTH(WGT_W), .DEPTH(MAX_LENGTH)) u_weight (
		.clk(clk), .we(cmd.load), .waddr(cnt_q[IW-1:0]), .wdata(lambda_value),
		.raddr(i_q[IW-1:0]), .rdata(wgt_rd)
	);
	sl1p_ram #(.WIDTH(IW), .DEPTH(MAX_LENGTH)) u_order (
		.clk(clk), .we(cmd.sort_wr), .waddr(acc_q[IW-1:0]), .wdata(i_q[IW-1:0]),
		.raddr(i_q[IW-1:0]), .rdata(order_rd)
	);
	sl1p_ram #(.WIDTH(IW), .DEPTH(MAX_LENGTH)) u_rank (
		.clk(clk), .we(cmd.sort_wr), .waddr(i_q[IW-1:0]), .wdata(acc_q[IW-1:0]),
		.raddr(j_q[IW-1:0]), .rdata(rank_rd)
	);
	sl1p_ram #(.WIDTH(STK_W), .DEPTH(MAX_LENGTH)) u_stack (
		.clk(clk), .we(stk_we), .waddr(depth_q[IW-1:0]),
		.wdata({top_sum_q, top_mean_q, top_start_q}),
		.raddr(IW'(depth_q - 1'b1)), .rdata(stk_rd)
	);
	sl1p_ram #(.WIDTH(MAG_W), .DEPTH(MAX_LENGTH)) u_byrank (
		.clk(clk), .we(cmd.fill_wr), .waddr(i_q[IW-1:0]), .wdata(clamp_d),
		.raddr(rank_rd), .rdata(byrank_rd)
	);

	// stable descending order: count entries that rank ahead
	assign gt = (mag_b_rd > cur_q) || ((mag_b_rd == cur_q) && (jd_q < i_q));

	// pooling arithmetic
	assign s_new       = $signed({{(SUM_W-MAG_W){1'b0}}, mag_a_rd})
	                   - $signed({{(SUM_W-WGT_W){1'b0}}, w_q});
	assign below_sum   = $signed(stk_rd[STK_W-1 -: SUM_W]);
	assign below_mean  = $signed(stk_rd[STK_W-SUM_W-1 -: SUM_W]);
	assign below_start = stk_rd[IW-1:0];
	assign merged_sum  = below_sum + top_sum_q;
	assign blk_len     = i_q - CW'(below_start) + 1'b1;
	assign div_start   = cmd.pool_merge && sts.merge_ok;
	assign stk_we      = cmd.pool_push && (i_q != '0);

	sl1p_div #(.N_W(SUM_W), .D_W(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(merged_sum),
		.divisor(blk_len), .done(div_done), .quotient(quot)
	);

	// negative means clamp to zero; a mean never exceeds 2^31
	assign clamp_d = (top_mean_q > 0) ? top_mean_q[MAG_W-1:0] : '0;

	// status
	always_comb begin
		sts.last_in    = last_element || (cnt_q == CW'(MAX_LENGTH - 1));
		sts.j_done     = (j_q == n_q) && !vld_q;
		sts.sort_last  = (i_q == n_q - 1'b1);
		sts.depth_zero = (depth_q == '0);
		sts.merge_ok   = below_mean <= top_mean_q;
		sts.div_done   = div_done;
		sts.fill_done  = (i_q == '0);
		sts.fill_pop   = (i_q[IW-1:0] == top_start_q);
		sts.emit_last  = (j_q == n_q - 1'b1);
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			jd_q    <= '0;
			acc_q   <= '0;
			depth_q <= '0;
			vld_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= cnt_q + 1'b1;
				if (sts.last_in) begin
					n_q <= cnt_q + 1'b1;
					i_q <= '0;
				end
			end
			if (cmd.sort_latch) begin
				j_q   <= '0;
				acc_q <= '0;
				vld_q <= 1'b0;
			end
			if (cmd.sort_scan) begin
				vld_q <= (j_q < n_q);
				jd_q  <= j_q;
				if (j_q < n_q) begin
					j_q <= j_q + 1'b1;
				end
				if (vld_q && gt) begin
					acc_q <= acc_q + 1'b1;
				end
			end
			if (cmd.sort_wr) begin
				if (sts.sort_last) begin
					i_q     <= '0;
					depth_q <= '0;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			if (stk_we) begin
				depth_q <= depth_q + 1'b1;
			end
			if (div_start || cmd.fill_pop) begin
				depth_q <= depth_q - 1'b1;
			end
			if (cmd.pool_next && !sts.sort_last) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.fill_wr) begin
				if (sts.fill_done) begin
					j_q <= '0;
				end else begin
					i_q <= i_q - 1'b1;
				end
			end
			if (cmd.emit_fire) begin
				if (sts.emit_last) begin
					cnt_q <= '0;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.sort_latch) begin
			cur_q <= mag_a_rd;
		end
		if (cmd.pool_wlatch) begin
			w_q <= wgt_rd;
		end
		if (cmd.pool_push) begin
			top_sum_q   <= s_new;
			top_mean_q  <= s_new;
			top_start_q <= i_q[IW-1:0];
		end
		if (div_start) begin
			top_sum_q   <= merged_sum;
			top_start_q <= below_start;
		end
		if (cmd.pool_div && div_done) begin
			top_mean_q <= quot;
		end
		if (cmd.fill_pop) begin
			top_mean_q  <= below_mean;
			top_start_q <= below_start;
		end
		// restore the sign; positive results saturate
		if (cmd.emit_cap) begin
			last_q <= sts.emit_last;
			case (sign_rd)
				SIGN_ZERO: result_q <= '0;
				SIGN_NEG:  result_q <= $signed(MAG_W'(0) - byrank_rd);
				default:   result_q <= byrank_rd[MAG_W-1] ? $signed({1'b0, {(MAG_W-1){1'b1}}})
				                                          : $signed(byrank_rd);
			endcase
		end
	end

	assign result_value = result_q;
	assign last_result  = last_q;

endmodule
`default_nettype wire

// ===== design/sl1p_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sl1p_ctrl
// Sequencer for load, sort, pool, fill and emit phases.
// ----------------------------------------------------------------------------
module sl1p_ctrl import sl1p_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire status_t sts,
	output cmd_t         cmd
);

	localparam logic [4:0] S_LOAD = 5'd0;
	localparam logic [4:0] S_SI   = 5'd1;
	localparam logic [4:0] S_SL   = 5'd2;
	localparam logic [4:0] S_SJ   = 5'd3;
	localparam logic [4:0] S_SW   = 5'd4;
	localparam logic [4:0] S_PR   = 5'd5;
	localparam logic [4:0] S_PR2  = 5'd6;
	localparam logic [4:0] S_PR3  = 5'd7;
	localparam logic [4:0] S_PC   = 5'd8;
	localparam logic [4:0] S_PM   = 5'd9;
	localparam logic [4:0] S_PD   = 5'd10;
	localparam logic [4:0] S_PN   = 5'd11;
	localparam logic [4:0] S_FW   = 5'd12;
	localparam logic [4:0] S_FL   = 5'd13;
	localparam logic [4:0] S_E    = 5'd14;
	localparam logic [4:0] S_E2   = 5'd15;
	localparam logic [4:0] S_E3   = 5'd16;
	localparam logic [4:0] S_EO   = 5'd17;

	logic [4:0] state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD: if (in_valid && sts.last_in) state_d = S_SI;
			S_SI:   state_d = S_SL;
			S_SL:   state_d = S_SJ;
			S_SJ:   if (sts.j_done) state_d = S_SW;
			S_SW:   state_d = sts.sort_last ? S_PR : S_SI;
			S_PR:   state_d = S_PR2;
			S_PR2:  state_d = S_PR3;
			S_PR3:  state_d = S_PC;
			S_PC:   state_d = sts.depth_zero ? S_PN : S_PM;
			S_PM:   state_d = sts.merge_ok ? S_PD : S_PN;
			S_PD:   if (sts.div_done) state_d = S_PC;
			S_PN:   state_d = sts.sort_last ? S_FW : S_PR;
			S_FW: begin
				if (sts.fill_done) state_d = S_E;
				else if (sts.fill_pop) state_d = S_FL;
			end
			S_FL:   state_d = S_FW;
			S_E:    state_d = S_E2;
			S_E2:   state_d = S_E3;
			S_E3:   state_d = S_EO;
			S_EO:   if (out_ready) state_d = sts.emit_last ? S_LOAD : S_E;
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// commands
	always_comb begin
		cmd             = '0;
		cmd.load        = (state_q == S_LOAD) && in_valid;
		cmd.sort_latch  = (state_q == S_SL);
		cmd.sort_scan   = (state_q == S_SJ);
		cmd.sort_wr     = (state_q == S_SW);
		cmd.mag_sel     = (state_q == S_PR2);
		cmd.pool_wlatch = (state_q == S_PR2);
		cmd.pool_push   = (state_q == S_PR3);
		cmd.pool_merge  = (state_q == S_PM);
		cmd.pool_div    = (state_q == S_PD);
		cmd.pool_next   = (state_q == S_PN);
		cmd.fill_wr     = (state_q == S_FW);
		cmd.fill_pop    = (state_q == S_FL);
		cmd.emit_cap    = (state_q == S_E3);
		cmd.emit_fire   = (state_q == S_EO) && out_ready;
	end

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = (state_q == S_EO);

endmodule
`default_nettype wire

// ===== design/sorted_l1_proximal_operator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_l1_proximal_operator_top
// Sorted-L1 proximal operator over a vector of Q15.16 coefficients.
// ----------------------------------------------------------------------------
// Load n coefficients (n up to MAX_LENGTH), one transaction per cycle, each
// with the weight for that sorted rank; the transaction flagged last, or the
// MAX_LENGTH-th, closes the vector. The block then ranks the magnitudes by a
// counting sort over a second magnitude RAM, pools adjacent violators on a
// RAM stack with a bit-serial divider per merge (at most n-1 merges), fills
// a per-rank result RAM one rank at a time, popping each pooled block as it
// ends, and emits n results in load order, each held until taken. Input is
// not accepted from the closing transaction until the last result has been
// taken. The fixed point scaling does not affect the logic.
// ----------------------------------------------------------------------------
module sorted_l1_proximal_operator_top import sl1p_pkg::*; #(
	parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic signed [MAG_W-1:0] beta_value,
	input  wire logic [WGT_W-1:0]        lambda_value,
	input  wire logic                    last_element,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [MAG_W-1:0]      result_value,
	output logic                         last_result
);

	cmd_t    cmd;
	status_t sts;

	sl1p_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	sl1p_datapath #(.MAX_LENGTH(MAX_LENGTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .beta_value(beta_value),
		.lambda_value(lambda_value), .last_element(last_element),
		.cmd(cmd), .sts(sts), .result_value(result_value),
		.last_result(last_result)
	);

	// loading and emitting never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is offered");

	// closing transaction stops loading
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && last_element) |=> !in_ready)
		else $error("still loading after the last coefficient");

	// taking the last result returns to loading
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_result) |=> in_ready)
		else $error("not ready for a new vector after the last result");

endmodule
`default_nettype wire
